[src/slsu_pkg.sv]
// ----------------------------------------------------------------------------
// slsu_pkg: shared types and constants of the string length sorter
// Holds the default sizes, the status codes and the sequencer states.
// ----------------------------------------------------------------------------
package slsu_pkg;

  localparam int unsigned DefMaxStrings = 128;
  localparam int unsigned DefMaxLen     = 128;
  localparam int unsigned CharW         = 8;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } slsu_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_RD_CHR,
    S_RD_OUT
  } slsu_state_e;

endpackage

[src/slsu_ram.sv]
// ----------------------------------------------------------------------------
// slsu_ram: simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slsu_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/string_length_sorter_unit.sv]
// ----------------------------------------------------------------------------
// string_length_sorter_unit: stable sort of byte strings by length
// Strings are kept in a character memory; a key memory holds {length, index}
// pairs kept in sorted order by inserting each string as it is closed.
// ----------------------------------------------------------------------------
// A byte load, set close, rejected string end or empty read is answered from idle;
// a kept string end reads and compares held keys downward, moving each longer
//   one up one place, then writes its own; a read fetches, then sends a byte.
// Throughput: one word at a time; the input waits until the result has left.
// Reset clears the control state only; both memories are undefined until written.
module string_length_sorter_unit #(
  parameter int unsigned MaxStrings = slsu_pkg::DefMaxStrings,
  parameter int unsigned MaxLen     = slsu_pkg::DefMaxLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tuser,   // [0] func
  input  logic       s_axis_tlast,   // string_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] char_out
  output logic [2:0] m_axis_tuser,   // [1:0] status, [2] string_end_out
  output logic       m_axis_tlast    // last_out
);

  import slsu_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxStrings + 1);
  localparam int unsigned LenW  = $clog2(MaxLen + 1);
  localparam int unsigned IdxW  = $clog2(MaxStrings);
  localparam int unsigned PosW  = $clog2(MaxLen);
  localparam int unsigned StDep = MaxStrings * MaxLen;
  localparam int unsigned AddrW = $clog2(StDep);
  localparam int unsigned KeyW  = LenW + IdxW;

  slsu_state_e state_q, state_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] cur_q, cur_d;
  logic [CntW-1:0] rs_q, rs_d;
  logic [PosW-1:0] rc_q, rc_d;
  logic            sorted_q, sorted_d;
  logic [IdxW-1:0] j_q, j_d;
  logic            send_q, send_d;
  logic            last_q, last_d;

  logic            out_vld_q, out_vld_d;
  slsu_status_e    out_stat_q, out_stat_d;
  logic [7:0]      out_char_q, out_char_d;
  logic            out_send_q, out_send_d;
  logic            out_last_q, out_last_d;

  logic            acc;
  logic [CntW-1:0] eff_cnt;
  logic [LenW-1:0] eff_cur;

  logic             key_we;
  logic [IdxW-1:0]  key_waddr, key_raddr;
  logic [KeyW-1:0]  key_wdata, key_rdata;
  logic [KeyW-1:0]  new_key;
  logic [LenW-1:0]  rd_len;
  logic [IdxW-1:0]  rd_idx;

  logic             chr_we;
  logic [AddrW-1:0] chr_waddr, chr_raddr;
  logic [7:0]       chr_rdata;

  assign s_axis_tready = (state_q == S_IDLE) && (!out_vld_q || m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;

  // A load after the set was closed starts a new, empty set.
  assign eff_cnt = sorted_q ? '0 : cnt_q;
  assign eff_cur = sorted_q ? '0 : cur_q;

  assign new_key = {cur_q, cnt_q[IdxW-1:0]};
  assign rd_len  = key_rdata[KeyW-1:IdxW];
  assign rd_idx  = key_rdata[IdxW-1:0];

  assign key_raddr = (state_q == S_INS_RD) ? (j_q - 1'b1) : rs_q[IdxW-1:0];
  assign chr_waddr = AddrW'(AddrW'(eff_cnt[IdxW-1:0]) * AddrW'(MaxLen))
                     + AddrW'(eff_cur[PosW-1:0]);
  assign chr_raddr = AddrW'(AddrW'(rd_idx) * AddrW'(MaxLen)) + AddrW'(rc_q);
  assign chr_we    = acc && !s_axis_tuser && !s_axis_tlast
                     && (eff_cnt < CntW'(MaxStrings)) && (eff_cur < LenW'(MaxLen));

  slsu_ram #(.DataW(KeyW), .Depth(MaxStrings)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  slsu_ram #(.DataW(8), .Depth(StDep)) u_chr_ram (
    .clk_i   (clk_i),
    .we_i    (chr_we),
    .waddr_i (chr_waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (chr_raddr),
    .rdata_o (chr_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (s_axis_tuser) begin
            if (sorted_q && (rs_q < cnt_q)) state_d = S_RD_CHR;
          end else if (s_axis_tlast && (eff_cur != '0) && (eff_cnt < CntW'(MaxStrings))
                       && (eff_cur < LenW'(MaxLen))) begin
            state_d = (eff_cnt == '0) ? S_INS_PUT : S_INS_RD;
          end
        end
      end
      S_INS_RD:  state_d = S_INS_CMP;
      S_INS_CMP: begin
        if (rd_len > cur_q) begin
          state_d = (j_q == IdxW'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_INS_PUT: state_d = S_IDLE;
      S_RD_CHR:  state_d = S_RD_OUT;
      S_RD_OUT:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    rs_d       = rs_q;
    rc_d       = rc_q;
    sorted_d   = sorted_q;
    j_d        = j_q;
    send_d     = send_q;
    last_d     = last_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_stat_d = out_stat_q;
    out_char_d = out_char_q;
    out_send_d = out_send_q;
    out_last_d = out_last_q;
    key_we     = 1'b0;
    key_waddr  = j_q;
    key_wdata  = new_key;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          out_char_d = '0;
          out_send_d = 1'b0;
          out_last_d = 1'b0;
          out_stat_d = STAT_OK;
          if (s_axis_tuser) begin
            if (!(sorted_q && (rs_q < cnt_q))) begin
              out_vld_d  = 1'b1;
              out_stat_d = STAT_EMPTY;
            end
          end else begin
            sorted_d = 1'b0;
            cnt_d    = eff_cnt;
            cur_d    = eff_cur;
            if (sorted_q) begin
              rs_d = '0;
              rc_d = '0;
            end
            if (!s_axis_tlast) begin
              out_vld_d = 1'b1;
              if (eff_cur < LenW'(MaxLen)) cur_d = eff_cur + 1'b1;
            end else if (eff_cur == '0) begin
              out_vld_d = 1'b1;
              sorted_d  = 1'b1;
              rs_d      = '0;
              rc_d      = '0;
            end else if (eff_cnt >= CntW'(MaxStrings)) begin
              out_vld_d  = 1'b1;
              out_stat_d = STAT_FULL;
              cur_d      = '0;
            end else if (eff_cur >= LenW'(MaxLen)) begin
              out_vld_d  = 1'b1;
              out_stat_d = STAT_TOO_LONG;
              cur_d      = '0;
            end else begin
              j_d = eff_cnt[IdxW-1:0];
            end
          end
        end
      end
      S_INS_RD: ;
      S_INS_CMP: begin
        key_we = 1'b1;
        if (rd_len > cur_q) begin
          // Shift the longer entry up one place and keep searching downward.
          key_wdata = key_rdata;
          j_d       = j_q - 1'b1;
        end else begin
          out_vld_d = 1'b1;
          cnt_d     = cnt_q + 1'b1;
          cur_d     = '0;
        end
      end
      S_INS_PUT: begin
        key_we    = 1'b1;
        out_vld_d = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        cur_d     = '0;
      end
      S_RD_CHR: begin
        send_d = ((LenW + 1)'(rc_q) + 1'b1) >= (LenW + 1)'(rd_len);
        last_d = ((CntW + 1)'(rs_q) + 1'b1) == (CntW + 1)'(cnt_q);
      end
      S_RD_OUT: begin
        out_vld_d  = 1'b1;
        out_char_d = chr_rdata;
        out_send_d = send_q;
        out_last_d = send_q && last_q;
        if (send_q) begin
          rs_d = rs_q + 1'b1;
          rc_d = '0;
        end else begin
          rc_d = rc_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      cur_q     <= '0;
      rs_q      <= '0;
      rc_q      <= '0;
      sorted_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cur_q     <= cur_d;
      rs_q      <= rs_d;
      rc_q      <= rc_d;
      sorted_q  <= sorted_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q        <= j_d;
    send_q     <= send_d;
    last_q     <= last_d;
    out_stat_q <= out_stat_d;
    out_char_q <= out_char_d;
    out_send_q <= out_send_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = {out_send_q, out_stat_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[src/slsu_checker.sv]
// ----------------------------------------------------------------------------
// slsu_assertions: port-level checks of the string length sorter
// Watches the output stream for flag and status consistency.
// ----------------------------------------------------------------------------
module slsu_assertions (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  import slsu_pkg::*;

  // A stalled word holds its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output word changed under stall");

  // A word that reports nothing to read carries no character and no flags.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] == STAT_EMPTY) |->
      (m_axis_tdata == 8'd0) && !m_axis_tuser[2] && !m_axis_tlast)
    else $error("empty read carries data");

  // The last character of the set also ends its string.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2])
    else $error("set end without string end");

  // Only a successful read raises the string end flag.
  a_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> (m_axis_tuser[1:0] == STAT_OK))
    else $error("string end flag on an error word");

endmodule

bind string_length_sorter_unit slsu_assertions u_slsu_assertions (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
